>>> src/nmea_sentence_checker_assert.svh
// Assertion macros for the NMEA sentence checker.
`ifndef NMEA_SENTENCE_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define NSC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("nmea_sentence_checker assertion failed");
`define NSC_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("nmea_sentence_checker assertion failed");
`else
`define NSC_ASSERT(lbl, prop)
`define NSC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> src/nsc_pkg.sv
// Types, character codes and per-byte helpers for the NMEA sentence checker.
package nsc_pkg;

   localparam logic [7:0] CH_DOLLAR = 8'd36;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_F = 8'd70;
   localparam logic [2:0] AFTER_STAR_MAX = 3'd4;
   localparam logic [6:0] LENGTH_MAX = 7'd127;

   typedef enum logic [1:0] {
      STATUS_VALID     = 2'd0,
      STATUS_MISMATCH  = 2'd1,
      STATUS_MALFORMED = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      logic       star_seen;
      logic [2:0] after_star_count;
      logic [3:0] digit_high;
      logic [3:0] digit_low;
      logic [7:0] running_xor;
   } ctx_type;

   localparam ctx_type CTX_CLEAR = '{
      star_seen: 1'b0, after_star_count: 3'd0,
      digit_high: 4'd0, digit_low: 4'd0, running_xor: 8'd0};

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = c[3:0];
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         v = 4'(c - 8'd55);
      end
      return v;
   endfunction

   function automatic ctx_type content_step(input ctx_type ctx, input logic [7:0] b);
      ctx_type r;
      r = ctx;
      if (!ctx.star_seen) begin
         if (b == CH_STAR) begin
            r.star_seen = 1'b1;
         end else begin
            r.running_xor = ctx.running_xor ^ b;
         end
      end else begin
         if (ctx.after_star_count == 3'd0) begin
            r.digit_high = hex_value(b);
         end else if (ctx.after_star_count == 3'd1) begin
            r.digit_low = hex_value(b);
         end
         if (ctx.after_star_count < AFTER_STAR_MAX) begin
            r.after_star_count = 3'(ctx.after_star_count + 3'd1);
         end
      end
      return r;
   endfunction

endpackage

>>> src/nmea_sentence_checker.sv
// NMEA 0183 sentence checker: byte-stream checksum verification, one verdict per sentence.
//
// req_*: one received character per word (req_tdata[7:0]).
// rsp_*: one verdict word per sentence that ends in CR LF or overflows;
//   rsp_tdata = {pad, sentence_length, received_checksum, computed_checksum, status}.
// Bytes outside a sentence are dropped until a '$'. No word comes out for
// bytes that only update the sentence state.
// Latency: the verdict is valid in the cycle after the LF (or the overflowing
// byte) is taken, held in the result register until rsp_tready.
// Throughput: one byte per cycle unless stalled; the per-byte state update is a single
// pass of XOR, hex decode and counter logic between the state registers.
// Stall: req_tready falls only while a verdict waits and rsp_tready is low;
// the waiting verdict stays unchanged.
// Reset: synchronous, active high; clears the sentence state and drops any
// pending verdict.
// BUFFER_BYTES sets the longest sentence kept (BUFFER_BYTES-1 bytes).
`include "nmea_sentence_checker_assert.svh"

module nmea_sentence_checker #(
   parameter int BUFFER_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [1:0] status, [9:2] computed_checksum,
                                    // [17:10] received_checksum, [24:18] sentence_length
);

   localparam int CountWidth = $clog2(BUFFER_BYTES);
   localparam logic [CountWidth-1:0] LastCount = CountWidth'(BUFFER_BYTES - 1);

   logic                  in_sentence_ff, in_sentence_in;
   logic [CountWidth-1:0] byte_count_ff, byte_count_in;
   logic                  prev_was_cr_ff, prev_was_cr_in;
   nsc_pkg::ctx_type      ctx_ff, ctx_in, ctx_mid;

   logic                  rsp_tvalid_ff;
   nsc_pkg::status_type   rsp_status_ff, res_status;
   logic [7:0]            rsp_computed_ff, res_computed;
   logic [7:0]            rsp_received_ff, res_received;
   logic [6:0]            rsp_length_ff, res_length;
   logic                  res_valid;
   logic                  req_accept;
   logic [CountWidth-1:0] count_inc;
   logic [7:0]            rx_byte;

   assign rx_byte    = req_tdata;
   assign req_tready = ~rsp_tvalid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign count_inc  = CountWidth'(byte_count_ff + 1'b1);

   always_comb begin
      in_sentence_in = in_sentence_ff;
      byte_count_in  = byte_count_ff;
      prev_was_cr_in = prev_was_cr_ff;
      ctx_in         = ctx_ff;
      ctx_mid        = prev_was_cr_ff ? nsc_pkg::content_step(ctx_ff, nsc_pkg::CH_CR) : ctx_ff;
      res_valid      = 1'b0;
      res_status     = nsc_pkg::STATUS_VALID;
      res_computed   = 8'd0;
      res_received   = 8'd0;
      res_length     = 7'd0;
      if (req_accept) begin
         if (!in_sentence_ff) begin
            if (rx_byte == nsc_pkg::CH_DOLLAR) begin
               in_sentence_in = 1'b1;
               byte_count_in  = CountWidth'(1);
               prev_was_cr_in = 1'b0;
               ctx_in         = nsc_pkg::CTX_CLEAR;
            end
         end else if (byte_count_ff >= LastCount) begin
            res_valid      = 1'b1;
            res_status     = nsc_pkg::STATUS_OVERFLOW;
            in_sentence_in = 1'b0;
            byte_count_in  = '0;
            prev_was_cr_in = 1'b0;
            ctx_in         = nsc_pkg::CTX_CLEAR;
         end else if (prev_was_cr_ff && rx_byte == nsc_pkg::CH_LF) begin
            res_valid    = 1'b1;
            res_computed = ctx_ff.running_xor;
            res_received = {ctx_ff.digit_high, ctx_ff.digit_low};
            if (!ctx_ff.star_seen || ctx_ff.after_star_count != 3'd2) begin
               res_status = nsc_pkg::STATUS_MALFORMED;
            end else if (ctx_ff.running_xor == res_received) begin
               res_status = nsc_pkg::STATUS_VALID;
            end else begin
               res_status = nsc_pkg::STATUS_MISMATCH;
            end
            if (32'(count_inc) > 32'(nsc_pkg::LENGTH_MAX)) begin
               res_length = nsc_pkg::LENGTH_MAX;
            end else begin
               res_length = 7'(count_inc);
            end
            in_sentence_in = 1'b0;
            byte_count_in  = '0;
            prev_was_cr_in = 1'b0;
            ctx_in         = nsc_pkg::CTX_CLEAR;
         end else begin
            byte_count_in = count_inc;
            if (rx_byte == nsc_pkg::CH_CR) begin
               ctx_in         = ctx_mid;
               prev_was_cr_in = 1'b1;
            end else begin
               ctx_in         = nsc_pkg::content_step(ctx_mid, rx_byte);
               prev_was_cr_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         byte_count_ff  <= '0;
         prev_was_cr_ff <= 1'b0;
         ctx_ff         <= nsc_pkg::CTX_CLEAR;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         byte_count_ff  <= byte_count_in;
         prev_was_cr_ff <= prev_was_cr_in;
         ctx_ff         <= ctx_in;
         if (req_accept) begin
            rsp_tvalid_ff <= res_valid;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && res_valid) begin
         rsp_status_ff   <= res_status;
         rsp_computed_ff <= res_computed;
         rsp_received_ff <= res_received;
         rsp_length_ff   <= res_length;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_length_ff, rsp_received_ff, rsp_computed_ff,
                        rsp_status_ff};

   `NSC_ASSERT(a_idle_count_zero, !in_sentence_ff |-> byte_count_ff == '0 && !prev_was_cr_ff)
   `NSC_ASSERT(a_after_star_sat, ctx_ff.after_star_count <= nsc_pkg::AFTER_STAR_MAX)
   `NSC_ASSERT(a_overflow_fields, rsp_tvalid_ff && rsp_status_ff == nsc_pkg::STATUS_OVERFLOW |-> rsp_computed_ff == 8'd0 && rsp_received_ff == 8'd0 && rsp_length_ff == 7'd0)
   `NSC_ASSERT(a_verdict_length, rsp_tvalid_ff && rsp_status_ff != nsc_pkg::STATUS_OVERFLOW |-> rsp_length_ff >= 7'd3)
   `NSC_ASSERT_ALWAYS(a_reset_drops, reset |=> !rsp_tvalid_ff && !in_sentence_ff)

endmodule
